// ===== sv/amrd_pkg.sv =====
package amrd_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;
   localparam int FPB_W      = 11;
   localparam int BC_W       = 4;
   localparam int CC_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFERS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS = 2'd2;

   localparam logic [FPB_W-1:0] FPB_RESET = 11'd1024;
   localparam logic [BC_W-1:0]  BC_RESET  = 4'd4;
   localparam logic [CC_W-1:0]  CC_RESET  = 2'd1;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_READ   = 2'd1,
      CMD_PAUSE  = 2'd2,
      CMD_RESUME = 2'd3
   } cmd_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } store_ctl_type;

   typedef struct packed {
      logic read_valid;
      logic dropped;
      logic stereo;
   } rsp_flags_type;

endpackage

// ===== sv/amrd_if.sv =====
interface amrd_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic [1:0]                    command;
   logic signed [SAMPLE_BITS-1:0] sample_ch0;
   logic signed [SAMPLE_BITS-1:0] sample_ch1;

   modport source (output valid, command, sample_ch0, sample_ch1, input ready);
   modport sink (input valid, command, sample_ch0, sample_ch1, output ready);
endinterface

interface amrd_rsp_if #(
   parameter int SAMPLE_BITS = 16,
   parameter int COUNT_BITS  = 4
);
   logic                          valid;
   logic                          ready;
   logic                          read_valid;
   logic signed [SAMPLE_BITS-1:0] out_ch0;
   logic signed [SAMPLE_BITS-1:0] out_ch1;
   logic                          dropped;
   logic [COUNT_BITS-1:0]         queued_buffers;
   logic [COUNT_BITS-1:0]         free_buffers;

   modport source (output valid, read_valid, out_ch0, out_ch1, dropped, queued_buffers,
                   free_buffers, input ready);
   modport sink (input valid, read_valid, out_ch0, out_ch1, dropped, queued_buffers,
                 free_buffers, output ready);
endinterface

// ===== sv/amrd_store.sv =====
module amrd_store
   import amrd_pkg::*;
#(
   parameter int DATA_W = 32,
   parameter int ADDR_W = 13,
   parameter int DEPTH  = 8192
) (
   input  logic              clock,
   input  store_ctl_type     ctl,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rdata_ff;

endmodule

// ===== sv/amrd_ring.sv =====
module amrd_ring
   import amrd_pkg::*;
#(
   parameter int MAX_BUFFERS = 8,
   parameter int MAX_FRAMES  = 1024,
   parameter int SAMPLE_BITS = 16,
   parameter int BUF_W       = 3,
   parameter int CNT_W       = 4,
   parameter int FRAME_W     = 10,
   parameter int ADDR_W      = 13
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  cmd_type                       cmd,
   input  logic signed [SAMPLE_BITS-1:0] sample0,
   input  logic signed [SAMPLE_BITS-1:0] sample1,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_data,
   output store_ctl_type                 ctl,
   output logic [ADDR_W-1:0]             wr_addr,
   output logic [2*SAMPLE_BITS-1:0]      wr_data,
   output logic [ADDR_W-1:0]             rd_addr,
   output rsp_flags_type                 flags,
   output logic [CNT_W-1:0]              queued_out,
   output logic [CNT_W-1:0]              free_out
);

   localparam int FE_W = ($clog2(MAX_FRAMES + 1) > FPB_W) ? $clog2(MAX_FRAMES + 1) : FPB_W;
   localparam int RESET_BUFS = (BC_RESET > MAX_BUFFERS) ? MAX_BUFFERS : BC_RESET;

   logic [FPB_W-1:0]   fpb_ff, fpb_in;
   logic [BC_W-1:0]    bc_ff, bc_in;
   logic [CC_W-1:0]    cc_ff, cc_in;
   logic [BUF_W-1:0]   widx_ff, widx_in;
   logic [BUF_W-1:0]   ridx_ff, ridx_in;
   logic [CNT_W-1:0]   free_ff, free_in;
   logic [CNT_W-1:0]   queued_ff, queued_in;
   logic [FRAME_W-1:0] wpos_ff, wpos_in;
   logic [FRAME_W-1:0] rpos_ff, rpos_in;
   logic               paused_ff, paused_in;

   logic [FE_W-1:0]    eff_frames;
   logic [CNT_W-1:0]   eff_bufs;
   logic [CNT_W-1:0]   csr_bufs;
   logic               stereo;
   logic               ring_full;
   logic [BUF_W-1:0]   ridx_drop;
   logic [CNT_W-1:0]   queued_drop;
   logic [CNT_W-1:0]   free_drop;
   logic [FRAME_W-1:0] wpos_drop;
   logic [FE_W-1:0]    wpos_inc;
   logic [FE_W-1:0]    rpos_inc;

   function automatic logic [CNT_W-1:0] clamp_bufs(input logic [BC_W-1:0] bc);
      if (bc == '0) begin
         return CNT_W'(1);
      end else if (32'(bc) > MAX_BUFFERS) begin
         return CNT_W'(MAX_BUFFERS);
      end
      return CNT_W'(bc);
   endfunction

   function automatic logic [BUF_W-1:0] next_idx(input logic [BUF_W-1:0] idx,
                                                input logic [CNT_W-1:0] nbufs);
      logic [CNT_W:0] n;
      n = (CNT_W + 1)'(idx) + 1'b1;
      return (n >= {1'b0, nbufs}) ? '0 : BUF_W'(n);
   endfunction

   function automatic logic [ADDR_W-1:0] addr_of(input logic [BUF_W-1:0] b,
                                                input logic [FRAME_W-1:0] p);
      return ADDR_W'(b) * ADDR_W'(MAX_FRAMES) + ADDR_W'(p);
   endfunction

   always_comb begin
      if (fpb_ff == '0) begin
         eff_frames = FE_W'(1);
      end else if (32'(fpb_ff) > MAX_FRAMES) begin
         eff_frames = FE_W'(MAX_FRAMES);
      end else begin
         eff_frames = FE_W'(fpb_ff);
      end
   end

   assign eff_bufs = clamp_bufs(bc_ff);
   assign csr_bufs = clamp_bufs(csr_data[BC_W-1:0]);
   assign stereo   = (cc_ff >= CC_W'(2));

   // drop of the oldest queued buffer when no buffer is open
   assign ring_full   = (free_ff == '0);
   assign ridx_drop   = ring_full ? next_idx(ridx_ff, eff_bufs) : ridx_ff;
   assign queued_drop = (ring_full && queued_ff != '0) ? queued_ff - 1'b1 : queued_ff;
   assign free_drop   = ring_full ? free_ff + 1'b1 : free_ff;
   assign wpos_drop   = ring_full ? '0 : wpos_ff;
   assign wpos_inc    = FE_W'(wpos_drop) + 1'b1;
   assign rpos_inc    = FE_W'(rpos_ff) + 1'b1;

   always_comb begin
      fpb_in    = fpb_ff;
      bc_in     = bc_ff;
      cc_in     = cc_ff;
      widx_in   = widx_ff;
      ridx_in   = ridx_ff;
      free_in   = free_ff;
      queued_in = queued_ff;
      wpos_in   = wpos_ff;
      rpos_in   = rpos_ff;
      paused_in = paused_ff;
      ctl       = '0;
      flags     = '0;
      wr_addr   = addr_of(widx_ff, wpos_drop);
      wr_data   = {stereo ? sample1 : SAMPLE_BITS'(0), sample0};
      rd_addr   = addr_of(ridx_ff, rpos_ff);
      flags.stereo = stereo;

      if (accept) begin
         unique case (cmd)
            CMD_WRITE: begin
               ctl.wr_en     = 1'b1;
               flags.dropped = ring_full;
               ridx_in       = ridx_drop;
               queued_in     = queued_drop;
               free_in       = free_drop;
               wpos_in       = wpos_inc[FRAME_W-1:0];
               if (ring_full) begin
                  rpos_in = '0;
               end
               if (wpos_inc >= eff_frames) begin
                  wpos_in   = '0;
                  free_in   = (free_drop != '0) ? free_drop - 1'b1 : '0;
                  widx_in   = next_idx(widx_ff, eff_bufs);
                  queued_in = queued_drop + 1'b1;
               end
            end
            CMD_READ: begin
               if (queued_ff != '0) begin
                  ctl.rd_en        = 1'b1;
                  flags.read_valid = 1'b1;
                  rpos_in          = rpos_inc[FRAME_W-1:0];
                  if (rpos_inc >= eff_frames) begin
                     rpos_in   = '0;
                     queued_in = queued_ff - 1'b1;
                     ridx_in   = next_idx(ridx_ff, eff_bufs);
                     free_in   = free_ff + 1'b1;
                  end
               end
            end
            CMD_PAUSE: begin
               if (!paused_ff) begin
                  paused_in = 1'b1;
                  widx_in   = '0;
                  ridx_in   = '0;
                  wpos_in   = '0;
                  rpos_in   = '0;
                  queued_in = '0;
                  free_in   = eff_bufs;
               end
            end
            CMD_RESUME: begin
               paused_in = 1'b0;
            end
            default: begin
            end
         endcase
      end

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAMES: begin
               fpb_in = csr_data[FPB_W-1:0];
            end
            CSR_BUFFERS: begin
               bc_in     = csr_data[BC_W-1:0];
               widx_in   = '0;
               ridx_in   = '0;
               wpos_in   = '0;
               rpos_in   = '0;
               queued_in = '0;
               free_in   = csr_bufs;
            end
            CSR_CHANNELS: begin
               cc_in = csr_data[CC_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign queued_out = queued_in;
   assign free_out   = free_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fpb_ff    <= FPB_RESET;
         bc_ff     <= BC_RESET;
         cc_ff     <= CC_RESET;
         widx_ff   <= '0;
         ridx_ff   <= '0;
         free_ff   <= CNT_W'(RESET_BUFS);
         queued_ff <= '0;
         wpos_ff   <= '0;
         rpos_ff   <= '0;
         paused_ff <= 1'b1;
      end else begin
         fpb_ff    <= fpb_in;
         bc_ff     <= bc_in;
         cc_ff     <= cc_in;
         widx_ff   <= widx_in;
         ridx_ff   <= ridx_in;
         free_ff   <= free_in;
         queued_ff <= queued_in;
         wpos_ff   <= wpos_in;
         rpos_ff   <= rpos_in;
         paused_ff <= paused_in;
      end
   end

   // every buffer is either queued or open for writing
   a_buffers_conserved: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W + 1)'(queued_ff) + (CNT_W + 1)'(free_ff)) == (CNT_W + 1)'(eff_bufs))
      else $error("queued plus free buffers differ from ring size");

   // a full ring has the writer parked on the oldest queued buffer
   a_full_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      (free_ff == '0) |-> (widx_ff == ridx_ff && wpos_ff == '0))
      else $error("full ring with writer off the oldest buffer");

   a_empty_read_idle: assert property (@(posedge clock) disable iff (reset)
      (accept && cmd == CMD_READ && queued_ff == '0 && !csr_wr_en) |=>
      ($stable(ridx_ff) && $stable(rpos_ff) && $stable(free_ff) && $stable(queued_ff)))
      else $error("read with nothing queued changed the ring");

endmodule

// ===== sv/audio_multibuffer_ring_drop_oldest.sv =====
// channel   dir   beat contents
// req_if    in    command, sample_ch0, sample_ch1
// rsp_if    out   read_valid, out_ch0, out_ch1, dropped, queued_buffers, free_buffers
// csr_*     in    csr_wr_en, csr_index, csr_data (no read-back)
//
// one beat per cycle while rsp_if is not stalled: the ring update is one pass of
// logic, and the sample store takes one write or one registered read per beat, so
// each result is registered and follows its request beat in the next cycle
// reset leaves the ring empty and paused; the sample store is not cleared
// a stalled response holds the pipeline: req_if.ready drops until rsp_if is taken
module audio_multibuffer_ring_drop_oldest
   import amrd_pkg::*;
#(
   parameter int MAX_BUFFERS = 8,
   parameter int MAX_FRAMES  = 1024,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   amrd_req_if.sink              req_if,
   amrd_rsp_if.source            rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int COUNT_BITS = $clog2(MAX_BUFFERS + 1);
   localparam int BUF_W   = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int FRAME_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int DEPTH   = MAX_BUFFERS * MAX_FRAMES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DATA_W  = 2 * SAMPLE_BITS;

   logic                  accept;
   store_ctl_type         ctl;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic [DATA_W-1:0]     wr_data;
   logic [DATA_W-1:0]     rd_data;
   rsp_flags_type         flags;
   logic [COUNT_BITS-1:0] queued_next;
   logic [COUNT_BITS-1:0] free_next;

   logic                  rsp_valid_ff;
   rsp_flags_type         flags_ff;
   logic [COUNT_BITS-1:0] queued_ff;
   logic [COUNT_BITS-1:0] free_ff;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   amrd_ring #(
      .MAX_BUFFERS (MAX_BUFFERS),
      .MAX_FRAMES  (MAX_FRAMES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .BUF_W       (BUF_W),
      .CNT_W       (COUNT_BITS),
      .FRAME_W     (FRAME_W),
      .ADDR_W      (ADDR_W)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .cmd        (cmd_type'(req_if.command)),
      .sample0    (req_if.sample_ch0),
      .sample1    (req_if.sample_ch1),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .ctl        (ctl),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .flags      (flags),
      .queued_out (queued_next),
      .free_out   (free_next)
   );

   amrd_store #(
      .DATA_W (DATA_W),
      .ADDR_W (ADDR_W),
      .DEPTH  (DEPTH)
   ) u_store (
      .clock   (clock),
      .ctl     (ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         flags_ff  <= flags;
         queued_ff <= queued_next;
         free_ff   <= free_next;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.read_valid     = flags_ff.read_valid;
   assign rsp_if.dropped        = flags_ff.dropped;
   assign rsp_if.queued_buffers = queued_ff;
   assign rsp_if.free_buffers   = free_ff;
   assign rsp_if.out_ch0        = flags_ff.read_valid ? rd_data[SAMPLE_BITS-1:0]
                                                      : SAMPLE_BITS'(0);
   assign rsp_if.out_ch1        = (flags_ff.read_valid && flags_ff.stereo)
                                  ? rd_data[DATA_W-1:SAMPLE_BITS] : SAMPLE_BITS'(0);

endmodule

// ===== tb/sv/amrd_checker.sv =====
`timescale 1ns / 100ps

module amrd_checker
   import amrd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   amrd_req_if                   req,
   amrd_rsp_if                   rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    errors,
   output int                    outstanding
);

   localparam int RING_MAX   = 8;
   localparam int FRAMES_MAX = 1024;

   typedef struct packed {
      logic        read_valid;
      logic [15:0] ch0;
      logic [15:0] ch1;
      logic        dropped;
      logic [3:0]  full_bufs;
      logic [3:0]  open_bufs;
   } ring_reply_type;

   logic [31:0]     frame_mem [RING_MAX*FRAMES_MAX];
   int              wr_buf, rd_buf, wr_pos, rd_pos, open_cnt, full_cnt;
   bit              paused;
   logic [FPB_W-1:0] fpb;
   logic [BC_W-1:0]  bufs;
   logic [CC_W-1:0]  chans;
   ring_reply_type  pending_replies[$];
   int              rsp_beats;

   function automatic int eff_frames();
      if (fpb == 0) return 1;
      if (fpb > FRAMES_MAX) return FRAMES_MAX;
      return int'(fpb);
   endfunction

   function automatic int eff_buffers();
      if (bufs == 0) return 1;
      if (bufs > RING_MAX) return RING_MAX;
      return int'(bufs);
   endfunction

   function automatic bit stereo();
      return chans >= 2;
   endfunction

   function automatic int next_buf(int idx);
      return (idx + 1 >= eff_buffers()) ? 0 : idx + 1;
   endfunction

   function automatic int mem_addr(int b, int p);
      return ((b < RING_MAX) ? b : 0) * FRAMES_MAX + ((p < FRAMES_MAX) ? p : 0);
   endfunction

   function automatic void empty_ring();
      wr_buf   = 0;
      rd_buf   = 0;
      wr_pos   = 0;
      rd_pos   = 0;
      full_cnt = 0;
      open_cnt = eff_buffers();
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_FRAMES: fpb = data[FPB_W-1:0];
         CSR_BUFFERS: begin
            bufs = data[BC_W-1:0];
            empty_ring();
         end
         CSR_CHANNELS: chans = data[CC_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic ring_reply_type advance_ring(cmd_type cmd, logic [15:0] s0,
                                                   logic [15:0] s1);
      ring_reply_type r;
      logic [31:0] word;
      r = '0;
      case (cmd)
         CMD_WRITE: begin
            // no open buffer: the oldest full one gives way
            if (open_cnt == 0) begin
               rd_buf = next_buf(rd_buf);
               if (full_cnt > 0) full_cnt--;
               rd_pos = 0;
               wr_pos = 0;
               open_cnt++;
               r.dropped = 1'b1;
            end
            frame_mem[mem_addr(wr_buf, wr_pos)] = {stereo() ? s1 : 16'h0000, s0};
            wr_pos++;
            if (wr_pos >= eff_frames()) begin
               wr_pos = 0;
               if (open_cnt > 0) open_cnt--;
               wr_buf = next_buf(wr_buf);
               full_cnt++;
            end
         end
         CMD_READ: begin
            if (full_cnt > 0) begin
               word = frame_mem[mem_addr(rd_buf, rd_pos)];
               r.read_valid = 1'b1;
               r.ch0 = word[15:0];
               r.ch1 = stereo() ? word[31:16] : 16'h0000;
               rd_pos++;
               if (rd_pos >= eff_frames()) begin
                  rd_pos = 0;
                  full_cnt--;
                  rd_buf = next_buf(rd_buf);
                  open_cnt++;
               end
            end
         end
         CMD_PAUSE: begin
            if (!paused) begin
               paused = 1'b1;
               empty_ring();
            end
         end
         default: paused = 1'b0;
      endcase
      r.full_bufs = full_cnt[3:0];
      r.open_bufs = open_cnt[3:0];
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      $display("[%0t] rsp beat %0d %s: got %h want %h", $time, rsp_beats, field, got, want);
      errors++;
   endtask

   task automatic check_reply();
      ring_reply_type want;
      if (pending_replies.size() == 0) begin
         report_mismatch("beat with nothing pending", 16'h0, 16'h0);
         return;
      end
      want = pending_replies.pop_front();
      if (rsp.read_valid !== want.read_valid)
         report_mismatch("read_valid", 16'(rsp.read_valid), 16'(want.read_valid));
      if (rsp.out_ch0 !== want.ch0)
         report_mismatch("out_ch0", rsp.out_ch0, want.ch0);
      if (rsp.out_ch1 !== want.ch1)
         report_mismatch("out_ch1", rsp.out_ch1, want.ch1);
      if (rsp.dropped !== want.dropped)
         report_mismatch("dropped", 16'(rsp.dropped), 16'(want.dropped));
      if (rsp.queued_buffers !== want.full_bufs)
         report_mismatch("queued_buffers", 16'(rsp.queued_buffers), 16'(want.full_bufs));
      if (rsp.free_buffers !== want.open_bufs)
         report_mismatch("free_buffers", 16'(rsp.free_buffers), 16'(want.open_bufs));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fpb    = FPB_RESET;
         bufs   = BC_RESET;
         chans  = CC_RESET;
         paused = 1'b1;
         empty_ring();
         pending_replies.delete();
      end else begin
         if (csr_wr_en) apply_csr(csr_index, csr_data);
         if (req.valid && req.ready)
            pending_replies.push_back(advance_ring(cmd_type'(req.command), req.sample_ch0,
                                                   req.sample_ch1));
         if (rsp.valid && rsp.ready) begin
            check_reply();
            rsp_beats++;
         end
      end
      outstanding = pending_replies.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import amrd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_data   = '0;
   logic                  src_valid  = 1'b0;
   logic [1:0]            src_cmd    = '0;
   logic [15:0]           src_ch0    = '0;
   logic [15:0]           src_ch1    = '0;
   logic                  sink_ready = 1'b0;
   int                    errors;
   int                    outstanding;
   int                    gap_odds   = 0;
   int                    stall_odds = 0;
   int                    stall_left = 0;
   int                    cur_frames = 1024;
   int                    beats_sent = 0;

   amrd_req_if req_if ();
   amrd_rsp_if rsp_if ();

   assign req_if.valid      = src_valid;
   assign req_if.command    = src_cmd;
   assign req_if.sample_ch0 = src_ch0;
   assign req_if.sample_ch1 = src_ch1;
   assign rsp_if.ready      = sink_ready;

   audio_multibuffer_ring_drop_oldest dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   amrd_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always #2 clock = ~clock;

   // response side back-pressure in bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         sink_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
         sink_ready <= 1'b0;
         stall_left <= $urandom_range(0, 13);
      end else begin
         sink_ready <= 1'b1;
      end
   end

   function automatic int frames_eff(logic [CSR_DATA_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > 1024) return 1024;
      return int'(raw);
   endfunction

   function automatic logic [15:0] any_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic int pick_odds();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 3;
         2: return 8;
         default: return 20;
      endcase
   endfunction

   task automatic send_beat(cmd_type cmd, logic [15:0] s0, logic [15:0] s1);
      if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         src_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      src_valid <= 1'b1;
      src_cmd   <= cmd;
      src_ch0   <= s0;
      src_ch1   <= s1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drain();
      src_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_beat(int write_pct);
      int      roll;
      cmd_type cmd;
      if (gap_odds != 0 && $urandom_range(0, 79) == 0) drain();
      roll = $urandom_range(0, 99);
      if (roll < write_pct) cmd = CMD_WRITE;
      else if (roll < 94) cmd = CMD_READ;
      else if (roll < 97) cmd = CMD_PAUSE;
      else cmd = CMD_RESUME;
      send_beat(cmd, any_sample(), any_sample());
   endtask

   initial begin
      int                    phase_len;
      int                    write_pct;
      logic [CSR_DATA_W-1:0] raw;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset config: paused, mono, large buffers
      send_beat(CMD_READ, 16'h0000, 16'h0000);
      send_beat(CMD_PAUSE, 16'h0000, 16'h0000);
      send_beat(CMD_WRITE, 16'h8000, 16'h7fff);
      send_beat(CMD_WRITE, 16'h7fff, 16'h8000);
      send_beat(CMD_RESUME, 16'hffff, 16'hffff);
      send_beat(CMD_PAUSE, 16'h0000, 16'h0000);
      drain();

      // two stereo buffers of two frames, then overflow
      csr_write(CSR_FRAMES, 11'd2);
      csr_write(CSR_BUFFERS, 11'd2);
      csr_write(CSR_CHANNELS, 11'd2);
      cur_frames = 2;
      send_beat(CMD_RESUME, 16'h0000, 16'h0000);
      send_beat(CMD_WRITE, 16'h7fff, 16'h8000);
      send_beat(CMD_WRITE, 16'h8000, 16'h7fff);
      send_beat(CMD_WRITE, 16'h0000, 16'hffff);
      send_beat(CMD_WRITE, 16'hffff, 16'h0000);
      send_beat(CMD_WRITE, 16'h5555, 16'haaaa);
      repeat (3) send_beat(CMD_READ, 16'h0000, 16'h0000);
      drain();

      // zero values in every register, and the unused index
      csr_write(CSR_FRAMES, 11'd0);
      csr_write(CSR_BUFFERS, 11'd0);
      csr_write(CSR_CHANNELS, 11'd0);
      csr_write(CSR_UNUSED, 11'h7ff);
      cur_frames = 1;
      send_beat(CMD_WRITE, 16'h1234, 16'h4321);
      send_beat(CMD_WRITE, 16'hffff, 16'hffff);
      send_beat(CMD_READ, 16'h0000, 16'h0000);
      send_beat(CMD_READ, 16'h0000, 16'h0000);
      drain();

      // buffer size shrinks while one holds three of its four frames
      csr_write(CSR_FRAMES, 11'd4);
      csr_write(CSR_BUFFERS, 11'd2);
      csr_write(CSR_CHANNELS, 11'd3);
      cur_frames = 4;
      repeat (3) send_beat(CMD_WRITE, any_sample(), any_sample());
      drain();
      csr_write(CSR_FRAMES, 11'd2);
      cur_frames = 2;
      send_beat(CMD_WRITE, any_sample(), any_sample());
      repeat (2) send_beat(CMD_READ, 16'h0000, 16'h0000);

      while (beats_sent < 950) begin
         drain();
         if (beats_sent >= 850) begin
            gap_odds   = 0;
            stall_odds = 0;
         end else begin
            gap_odds   = pick_odds();
            stall_odds = pick_odds();
         end
         if ($urandom_range(0, 3) == 0) begin
            // buffers no larger than before, without emptying the ring
            raw = ($urandom_range(0, 7) == 0) ? '0 : CSR_DATA_W'($urandom_range(1, cur_frames));
            csr_write(CSR_FRAMES, raw);
            cur_frames = frames_eff(raw);
            if ($urandom_range(0, 1) == 1) csr_write(CSR_CHANNELS, CSR_DATA_W'($urandom_range(0, 3)));
         end else begin
            case ($urandom_range(0, 15))
               0: raw = '0;
               1: raw = 11'd1024;
               2: raw = CSR_DATA_W'($urandom_range(1025, 2047));
               3: raw = CSR_DATA_W'($urandom_range(7, 40));
               default: raw = CSR_DATA_W'($urandom_range(1, 6));
            endcase
            csr_write(CSR_FRAMES, raw);
            cur_frames = frames_eff(raw);
            case ($urandom_range(0, 9))
               0: csr_write(CSR_BUFFERS, '0);
               1: csr_write(CSR_BUFFERS, CSR_DATA_W'($urandom_range(9, 15)));
               default: csr_write(CSR_BUFFERS, CSR_DATA_W'($urandom_range(1, 8)));
            endcase
            csr_write(CSR_CHANNELS, CSR_DATA_W'($urandom_range(0, 3)));
            if ($urandom_range(0, 5) == 0) csr_write(CSR_UNUSED, CSR_DATA_W'($urandom));
         end
         write_pct = $urandom_range(25, 75);
         phase_len = $urandom_range(30, 110);
         repeat (phase_len) random_beat(write_pct);
      end

      drain();
      repeat (4) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("** audio_multibuffer_ring_drop_oldest: PASSED **");
      end else begin
         $display("** audio_multibuffer_ring_drop_oldest: FAILED **");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("** audio_multibuffer_ring_drop_oldest: FAILED **");
      $finish;
   end

endmodule
